### rtl/nc_pkg.sv
package nc_pkg;

  localparam int ENTRIES = 16;
  localparam int REQ_MAX = 16;
  localparam int REQ_CW = 5;
  localparam int TIMER_W = 22;
  localparam int CFG_W = 22;
  localparam int CFG_IW = 3;

  localparam logic [2:0] ST_INCOMPLETE = 3'd0;
  localparam logic [2:0] ST_REACHABLE = 3'd1;
  localparam logic [2:0] ST_STALE = 3'd2;
  localparam logic [2:0] ST_DELAY = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;

  localparam logic [2:0] ACT_LOOKUP = 3'd0;
  localparam logic [2:0] ACT_ADVERT = 3'd1;
  localparam logic [2:0] ACT_SOLICIT = 3'd2;
  localparam logic [2:0] ACT_CONFIRM = 3'd3;
  localparam logic [2:0] ACT_TICK = 3'd4;

  localparam logic [CFG_IW-1:0] REG_REACHABLE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DELAY = 3'd1;
  localparam logic [CFG_IW-1:0] REG_RETRANS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_UCAST = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_MCAST = 3'd4;

  localparam logic [21:0] RST_REACHABLE = 22'd30000;
  localparam logic [15:0] RST_DELAY = 16'd5000;
  localparam logic [15:0] RST_RETRANS = 16'd1000;
  localparam logic [3:0] RST_MAX_UCAST = 4'd3;
  localparam logic [3:0] RST_MAX_MCAST = 4'd3;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [47:0] link;
    logic [2:0] st;
    logic [TIMER_W-1:0] timer;
    logic [3:0] probes;
  } nc_rec_t;

  typedef struct packed {
    logic kind;
    logic resolved;
    logic present;
    logic [2:0] nbr_state;
    logic [47:0] link_addr;
    logic [63:0] target_high;
    logic [63:0] target_low;
    logic table_full;
    logic last;
  } nc_out_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic apply;
    logic emit_req;
    logic emit_resp;
    logic take;
  } nc_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic last_idx;
    logic tick;
    logic tick_emit;
    logic alloc;
  } nc_sts_t;

endpackage

### rtl/nc_evt_if.sv
interface nc_evt_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [47:0] link_addr_in;
  logic solicited;
  logic override;
  logic [15:0] delta_ms;

  modport source (output valid, action, addr_high, addr_low, link_addr_in, solicited,
                  override, delta_ms, input ready);
  modport sink (input valid, action, addr_high, addr_low, link_addr_in, solicited,
                override, delta_ms, output ready);
endinterface

### rtl/nc_res_if.sv
interface nc_res_if;
  logic valid;
  logic ready;
  logic kind;
  logic resolved;
  logic present;
  logic [2:0] nbr_state;
  logic [47:0] link_addr;
  logic [63:0] target_high;
  logic [63:0] target_low;
  logic table_full;
  logic last;

  modport source (output valid, kind, resolved, present, nbr_state, link_addr, target_high,
                  target_low, table_full, last, input ready);
  modport sink (input valid, kind, resolved, present, nbr_state, link_addr, target_high,
                target_low, table_full, last, output ready);
endinterface

### rtl/nc_datapath.sv
module nc_datapath #(
  parameter int ENTRIES = nc_pkg::ENTRIES
) (
  input  logic clk,
  input  logic rst,
  nc_evt_if.sink evt,
  nc_res_if.source res,
  input  logic cfg_we,
  input  logic [nc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nc_pkg::CFG_W-1:0] cfg_data,
  input  nc_pkg::nc_cmd_t cmd,
  output nc_pkg::nc_sts_t sts
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [21:0] reach_ms;
  logic [15:0] delay_ms;
  logic [15:0] retrans_ms;
  logic [3:0] max_ucast;
  logic [3:0] max_mcast;

  logic [2:0] act;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [47:0] mac;
  logic sol;
  logic ovr;
  logic [15:0] ela;

  nc_pkg::nc_rec_t mem [ENTRIES];
  nc_pkg::nc_rec_t rd_q;
  logic [ENTRIES-1:0] vld;

  logic [IW-1:0] idx;
  logic fnd;
  logic [IW-1:0] sidx;
  nc_pkg::nc_rec_t m;
  logic fr;
  logic [IW-1:0] fidx;
  logic res_q;
  logic full_q;
  logic [nc_pkg::REQ_CW-1:0] req_cnt;

  logic o_valid;
  nc_pkg::nc_out_t o_q;

  nc_pkg::nc_rec_t tr;
  logic tv;
  logic temit;
  logic [47:0] tdest;
  logic tmatch;

  nc_pkg::nc_rec_t ar;
  logic awr;
  logic [IW-1:0] aidx;
  logic apres;
  logic aresolved;
  logic afull;
  logic aalloc;
  logic asetv;
  logic had;
  logic differs;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_ms <= nc_pkg::RST_REACHABLE;
      delay_ms <= nc_pkg::RST_DELAY;
      retrans_ms <= nc_pkg::RST_RETRANS;
      max_ucast <= nc_pkg::RST_MAX_UCAST;
      max_mcast <= nc_pkg::RST_MAX_MCAST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nc_pkg::REG_REACHABLE: reach_ms <= cfg_data[21:0];
        nc_pkg::REG_DELAY:     delay_ms <= cfg_data[15:0];
        nc_pkg::REG_RETRANS:   retrans_ms <= cfg_data[15:0];
        nc_pkg::REG_MAX_UCAST: max_ucast <= cfg_data[3:0];
        nc_pkg::REG_MAX_MCAST: max_mcast <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Per-slot aging for a time tick.
  always_comb begin
    tr = rd_q;
    tv = vld[idx];
    temit = 1'b0;
    tdest = '0;
    if (vld[idx] && rd_q.st != nc_pkg::ST_STALE) begin
      if ({6'd0, ela} < rd_q.timer) begin
        tr.timer = rd_q.timer - {6'd0, ela};
      end else begin
        unique case (rd_q.st)
          nc_pkg::ST_REACHABLE: begin
            tr.st = nc_pkg::ST_STALE;
            tr.timer = '0;
            tr.probes = '0;
          end
          nc_pkg::ST_DELAY: begin
            tr.st = nc_pkg::ST_PROBE;
            tr.timer = {6'd0, retrans_ms};
            tr.probes = 4'd1;
            temit = 1'b1;
            tdest = rd_q.link;
          end
          nc_pkg::ST_PROBE: begin
            if (rd_q.probes >= max_ucast) begin
              tv = 1'b0;
            end else begin
              tr.probes = rd_q.probes + 4'd1;
              tr.timer = {6'd0, retrans_ms};
              temit = 1'b1;
              tdest = rd_q.link;
            end
          end
          default: begin
            if (rd_q.probes >= max_mcast) begin
              tv = 1'b0;
            end else begin
              tr.probes = rd_q.probes + 4'd1;
              tr.timer = {6'd0, retrans_ms};
              temit = 1'b1;
            end
          end
        endcase
      end
    end
    tmatch = tv && rd_q.addr_high == hi && rd_q.addr_low == lo;
  end

  // Update of the addressed entry for the non-tick events.
  always_comb begin
    ar = m;
    awr = 1'b0;
    aidx = sidx;
    apres = fnd;
    aresolved = 1'b0;
    afull = 1'b0;
    aalloc = 1'b0;
    asetv = 1'b0;
    had = m.st != nc_pkg::ST_INCOMPLETE;
    differs = mac != '0 && mac != m.link;
    unique case (act)
      nc_pkg::ACT_LOOKUP: begin
        if (!fnd) begin
          if (!fr) begin
            afull = 1'b1;
          end else begin
            aalloc = 1'b1;
            asetv = 1'b1;
            awr = 1'b1;
            aidx = fidx;
            apres = 1'b1;
            ar = '{addr_high: hi, addr_low: lo, link: '0, st: nc_pkg::ST_INCOMPLETE,
                   timer: {6'd0, retrans_ms}, probes: 4'd1};
          end
        end else if (had) begin
          aresolved = 1'b1;
          if (m.st == nc_pkg::ST_STALE) begin
            awr = 1'b1;
            ar.st = nc_pkg::ST_DELAY;
            ar.timer = {6'd0, delay_ms};
            ar.probes = '0;
          end
        end
      end
      nc_pkg::ACT_ADVERT: begin
        if (fnd) begin
          if (!had && mac == '0) begin
            awr = 1'b0;
          end else if (differs && had && !ovr) begin
            if (m.st == nc_pkg::ST_REACHABLE) begin
              awr = 1'b1;
              ar.st = nc_pkg::ST_STALE;
              ar.timer = '0;
              ar.probes = '0;
            end
          end else begin
            awr = 1'b1;
            if (mac != '0) begin
              ar.link = mac;
            end
            if (sol) begin
              ar.st = nc_pkg::ST_REACHABLE;
              ar.timer = reach_ms;
              ar.probes = '0;
            end else if (differs || !had) begin
              ar.st = nc_pkg::ST_STALE;
              ar.timer = '0;
              ar.probes = '0;
            end
          end
        end
      end
      nc_pkg::ACT_SOLICIT: begin
        if (mac != '0) begin
          if (!fnd) begin
            if (fr) begin
              asetv = 1'b1;
              awr = 1'b1;
              aidx = fidx;
              apres = 1'b1;
              ar = '{addr_high: hi, addr_low: lo, link: mac, st: nc_pkg::ST_STALE,
                     timer: '0, probes: '0};
            end
          end else begin
            awr = 1'b1;
            ar.link = mac;
            if (m.link != mac || !had) begin
              ar.st = nc_pkg::ST_STALE;
              ar.timer = '0;
              ar.probes = '0;
            end
          end
        end
      end
      nc_pkg::ACT_CONFIRM: begin
        if (fnd && had) begin
          awr = 1'b1;
          ar.st = nc_pkg::ST_REACHABLE;
          ar.timer = reach_ms;
          ar.probes = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[idx];
    if (cmd.commit && act == nc_pkg::ACT_TICK && (tv != vld[idx] || vld[idx])) begin
      mem[idx] <= tr;
    end else if (cmd.apply && awr) begin
      mem[aidx] <= ar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.commit && act == nc_pkg::ACT_TICK) begin
      vld[idx] <= tv;
    end else if (cmd.apply && asetv) begin
      vld[aidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= evt.action;
      hi <= evt.addr_high;
      lo <= evt.addr_low;
      mac <= evt.link_addr_in;
      sol <= evt.solicited;
      ovr <= evt.override;
      ela <= evt.delta_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      fnd <= 1'b0;
      fr <= 1'b0;
      res_q <= 1'b0;
      full_q <= 1'b0;
      req_cnt <= '0;
    end else if (cmd.load) begin
      idx <= '0;
      fnd <= 1'b0;
      fr <= 1'b0;
      res_q <= 1'b0;
      full_q <= 1'b0;
      req_cnt <= '0;
    end else if (cmd.commit) begin
      idx <= idx + 1'b1;
      if (act == nc_pkg::ACT_TICK) begin
        if (tmatch && !fnd) begin
          fnd <= 1'b1;
          sidx <= idx;
          m <= tr;
        end
        if (sts.tick_emit) begin
          req_cnt <= req_cnt + 1'b1;
        end
      end else begin
        if (vld[idx] && rd_q.addr_high == hi && rd_q.addr_low == lo && !fnd) begin
          fnd <= 1'b1;
          sidx <= idx;
          m <= rd_q;
        end
        if (!vld[idx] && !fr) begin
          fr <= 1'b1;
          fidx <= idx;
        end
      end
    end else if (cmd.apply) begin
      m <= ar;
      fnd <= apres;
      sidx <= aidx;
      res_q <= aresolved;
      full_q <= afull;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit_req || cmd.emit_resp || (cmd.commit && sts.tick_emit)) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sts.tick_emit) begin
      o_q <= '{kind: 1'b1, resolved: 1'b0, present: 1'b1, nbr_state: tr.st,
               link_addr: tdest, target_high: rd_q.addr_high, target_low: rd_q.addr_low,
               table_full: 1'b0, last: 1'b0};
    end else if (cmd.emit_req) begin
      o_q <= '{kind: 1'b1, resolved: 1'b0, present: 1'b1, nbr_state: nc_pkg::ST_INCOMPLETE,
               link_addr: '0, target_high: m.addr_high, target_low: m.addr_low,
               table_full: 1'b0, last: 1'b0};
    end else if (cmd.emit_resp) begin
      o_q <= '{kind: 1'b0, resolved: res_q, present: fnd,
               nbr_state: fnd ? m.st : nc_pkg::ST_INCOMPLETE,
               link_addr: fnd ? m.link : 48'd0, target_high: '0, target_low: '0,
               table_full: full_q, last: 1'b1};
    end
  end

  assign evt.ready = cmd.take;
  assign res.valid = o_valid;
  assign res.kind = o_q.kind;
  assign res.resolved = o_q.resolved;
  assign res.present = o_q.present;
  assign res.nbr_state = o_q.nbr_state;
  assign res.link_addr = o_q.link_addr;
  assign res.target_high = o_q.target_high;
  assign res.target_low = o_q.target_low;
  assign res.table_full = o_q.table_full;
  assign res.last = o_q.last;

  always_comb begin
    sts.in_valid = evt.valid;
    sts.out_free = !o_valid || res.ready;
    sts.last_idx = idx == IW'(ENTRIES - 1);
    sts.tick = act == nc_pkg::ACT_TICK;
    sts.tick_emit = act == nc_pkg::ACT_TICK && temit &&
                    req_cnt < nc_pkg::REQ_CW'(nc_pkg::REQ_MAX);
    sts.alloc = aalloc;
  end

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_resp |-> !cmd.emit_req && !cmd.commit)
    else $error("two beats emitted in one cycle");
  a_load_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> idx == '0 && !fnd && !fr)
    else $error("scan not restarted on a new event");
  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_resp && full_q |-> !fnd && act == nc_pkg::ACT_LOOKUP)
    else $error("table full flagged with an entry present");
  a_alloc_req: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_req |-> fnd && m.st == nc_pkg::ST_INCOMPLETE && vld[sidx])
    else $error("solicitation request without a fresh incomplete entry");

endmodule

### rtl/nc_ctrl.sv
module nc_ctrl (
  input  logic clk,
  input  logic rst,
  input  nc_pkg::nc_sts_t sts,
  output nc_pkg::nc_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_APPLY = 6'b001000,
    S_AREQ  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.tick_emit || sts.out_free) begin
          cmd.commit = 1'b1;
          if (!sts.last_idx) begin
            state_next = S_READ;
          end else if (sts.tick) begin
            state_next = S_RESP;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = sts.alloc ? S_AREQ : S_RESP;
      end
      S_AREQ: begin
        if (sts.out_free) begin
          cmd.emit_req = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/ipv6_neighbour_cache_top.sv
// Neighbor cache of ENTRIES slots keyed by the 128-bit IPv6 address. Every event sweeps all
// slots through the single-port slot memory, each slot in a read state (address) and then an
// evaluate state (registered read data). After the sweep, any event other than a tick also
// applies the update of the addressed entry, and a lookup miss that allocates a slot then
// sends its solicitation request ahead of the response beat. A tick walks the slots in order
// and emits each solicitation request as it ages that slot, stalling the sweep while the
// output register is still occupied. Results of one event end with the response beat,
// marked by last.
module ipv6_neighbour_cache_top #(
  parameter int ENTRIES = nc_pkg::ENTRIES
) (
  input  logic clk,
  input  logic rst,
  nc_evt_if.sink evt,
  nc_res_if.source res,
  input  logic cfg_we,
  input  logic [nc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nc_pkg::CFG_W-1:0] cfg_data
);

  nc_pkg::nc_cmd_t cmd;
  nc_pkg::nc_sts_t sts;

  nc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  nc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
